>>> hdl/tgwe_pkg.sv
// ----------------------------------------------------------------------------
// Typed graph walk engine package
// Shared codes, constants and types of the graph walk engine.
// ----------------------------------------------------------------------------
package tgwe_pkg;

  localparam int MAX_NODES_DEF      = 32;
  localparam int RELATION_TYPES_DEF = 4;

  localparam int WEIGHT_W = 32;

  typedef enum logic [1:0] {
    OP_ADD_NODE = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_START    = 2'd2,
    OP_STEP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_VISIT  = 2'd0,
    K_EDGE   = 2'd1,
    K_DONE   = 2'd2,
    K_REJECT = 2'd3
  } kind_t;

endpackage

>>> hdl/tgwe_edge_mem.sv
// ----------------------------------------------------------------------------
// Graph walk edge store
// Adjacency rows (one bit per end node) and the edge weight memory, both
// synchronous with registered read data. Presence rows are cleared by
// a sweep after reset; weights are undefined until written.
// ----------------------------------------------------------------------------
module tgwe_edge_mem
  import tgwe_pkg::*;
#(
  parameter int MAX_NODES      = MAX_NODES_DEF,
  parameter int RELATION_TYPES = RELATION_TYPES_DEF,
  localparam int NIW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int ROWS = RELATION_TYPES * MAX_NODES,
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int WAW  = RAW + NIW
) (
  input  logic                clk,
  input  logic                row_we,
  input  logic [RAW-1:0]      row_waddr,
  input  logic [MAX_NODES-1:0] row_wdata,
  input  logic [RAW-1:0]      row_raddr,
  output logic [MAX_NODES-1:0] row_rdata,
  input  logic                wt_we,
  input  logic [WAW-1:0]      wt_waddr,
  input  logic [WEIGHT_W-1:0] wt_wdata,
  input  logic [WAW-1:0]      wt_raddr,
  output logic [WEIGHT_W-1:0] wt_rdata
);

  logic [MAX_NODES-1:0] row_mem [ROWS];
  logic [WEIGHT_W-1:0]  wt_mem  [ROWS*MAX_NODES];

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rdata <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_wdata;
    end
    wt_rdata <= wt_mem[wt_raddr];
  end

endmodule

>>> hdl/typed_graph_walk_engine_core.sv
// ----------------------------------------------------------------------------
// Typed graph walk engine
// Directed weighted graph store with breadth-first or depth-first walks.
// ----------------------------------------------------------------------------
// Usage: an item (op, node_a, node_b, relation, edge_weight_in) is taken at
// a clock edge where start is high and busy is low. Each item gives at most
// one result, shown for one cycle with done_strobe high; the receiver cannot
// stall, so results are never held. walk_order is written through
// cfg_we/cfg_data by the user only while idle; the block does not enforce it.
// Sequencing: a start and every rejected item answer in the cycle after the
// accepting edge; these and an accepted add node leave busy low. Add edge
// holds busy in S_EDGE while the adjacency row is written back. A step reads
// and scans an open row (S_RDROW, S_SCAN), pops, reads and scans each
// further row (S_POP, S_RDROW, S_SCAN), then reads the weight and registers
// an edge result (S_WT, S_OUT), or ends in S_POP on an empty frontier. The
// result shows in the first cycle after busy drops. The single adjacency row
// port sets this sequence. Reset: rst clears control state, then sweeps all
// RELATION_TYPES*MAX_NODES adjacency rows to zero, one per cycle, busy high.
// ----------------------------------------------------------------------------
module typed_graph_walk_engine_core
  import tgwe_pkg::*;
#(
  parameter int MAX_NODES      = MAX_NODES_DEF,
  parameter int RELATION_TYPES = RELATION_TYPES_DEF,
  localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int RW  = (RELATION_TYPES > 1) ? $clog2(RELATION_TYPES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic [NIW-1:0]      node_a,
  input  logic [NIW-1:0]      node_b,
  input  logic [RW-1:0]       relation,
  input  logic signed [WEIGHT_W-1:0] edge_weight_in,
  input  logic                cfg_we,
  input  logic                cfg_data,
  output logic                done_strobe,
  output logic [1:0]          kind,
  output logic [NIW-1:0]      from_node,
  output logic [NIW-1:0]      to_node,
  output logic signed [WEIGHT_W-1:0] edge_weight_out,
  output logic                first_visit
);

  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int ROWS = RELATION_TYPES * MAX_NODES;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WAW  = RAW + NIW;
  localparam int SCW  = $clog2(ROWS + 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_EDGE  = 8'b0000_0100,
    S_POP   = 8'b0000_1000,
    S_RDROW = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_WT    = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic              walk_order;
  logic [CW-1:0]     node_count;
  logic [MAX_NODES-1:0] visited;
  logic [NIW-1:0]    frontier [MAX_NODES];
  logic [CW-1:0]     head, tail;
  logic [NIW-1:0]    cur;
  logic [CW-1:0]     scan_pos;
  logic [RW-1:0]     wrel;
  logic              row_open;
  logic              walk_active;
  logic [SCW-1:0]    clr_cnt;

  // Latched request.
  logic [NIW-1:0]    req_a, req_b;
  logic [RW-1:0]     req_rel;
  logic [WEIGHT_W-1:0] req_w;

  // Edge found by the scan.
  logic [NIW-1:0]    hit_e;
  logic              hit_fv;

  // Memory ports.
  logic                 row_we;
  logic [RAW-1:0]       row_waddr, row_raddr;
  logic [MAX_NODES-1:0] row_wdata, row_rdata;
  logic                 wt_we;
  logic [WAW-1:0]       wt_waddr, wt_raddr;
  logic [WEIGHT_W-1:0]  wt_rdata;

  tgwe_edge_mem #(.MAX_NODES(MAX_NODES), .RELATION_TYPES(RELATION_TYPES)) u_mem (
    .clk(clk),
    .row_we(row_we), .row_waddr(row_waddr), .row_wdata(row_wdata),
    .row_raddr(row_raddr), .row_rdata(row_rdata),
    .wt_we(wt_we), .wt_waddr(wt_waddr), .wt_wdata(req_w),
    .wt_raddr(wt_raddr), .wt_rdata(wt_rdata)
  );

  // Input decode.
  logic a_ok, b_ok, rel_ok;
  assign a_ok   = (CW'(node_a) < node_count);
  assign b_ok   = (CW'(node_b) < node_count);
  assign rel_ok = (32'(relation) < RELATION_TYPES);

  // Masked scan of the row from scan_pos upward.
  logic [MAX_NODES-1:0] masked;
  logic                 any_hit;
  logic [NIW-1:0]       first_e;
  always_comb begin
    masked  = '0;
    any_hit = 1'b0;
    first_e = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      masked[i] = row_rdata[i] && (CW'(i) >= scan_pos);
    end
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (masked[i]) begin
        any_hit = 1'b1;
        first_e = NIW'(i);
      end
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  logic fr_empty;
  assign fr_empty = (head >= tail);

  always_comb begin
    row_raddr = RAW'((32'(req_rel) * MAX_NODES) + 32'(req_a));
    if (state == S_POP || state == S_RDROW) begin
      row_raddr = RAW'((32'(wrel) * MAX_NODES) + 32'(cur));
    end
    if (state == S_IDLE) begin
      row_raddr = RAW'((32'(relation) * MAX_NODES) + 32'(node_a));
    end
    wt_raddr  = WAW'((32'(wrel) * MAX_NODES + 32'(cur)) * MAX_NODES + 32'(hit_e));
    wt_waddr  = WAW'((32'(req_rel) * MAX_NODES + 32'(req_a)) * MAX_NODES + 32'(req_b));
    row_waddr = (state == S_CLEAR) ? RAW'(clr_cnt)
                                   : RAW'((32'(req_rel) * MAX_NODES) + 32'(req_a));
    row_wdata = '0;
    row_we    = 1'b0;
    wt_we     = 1'b0;
    if (state == S_CLEAR) begin
      row_we = 1'b1;
    end else if (state == S_EDGE) begin
      row_we = 1'b1;
      wt_we  = 1'b1;
      row_wdata = row_rdata;
      row_wdata[req_b] = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (32'(clr_cnt) == ROWS - 1) state_next = S_IDLE;
      S_IDLE: begin
        if (accept && op == OP_ADD_EDGE && a_ok && b_ok && rel_ok) begin
          state_next = S_EDGE;
        end else if (accept && op == OP_STEP && walk_active) begin
          state_next = row_open ? S_RDROW : S_POP;
        end
      end
      S_EDGE:  state_next = S_IDLE;
      S_POP:   state_next = fr_empty ? S_IDLE : S_RDROW;
      S_RDROW: state_next = S_SCAN;
      S_SCAN:  state_next = any_hit ? S_WT : S_POP;
      S_WT:    state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      walk_order  <= 1'b0;
      node_count  <= '0;
      visited     <= '0;
      head        <= '0;
      tail        <= '0;
      cur         <= '0;
      scan_pos    <= '0;
      wrel        <= '0;
      row_open    <= 1'b0;
      walk_active <= 1'b0;
      done_strobe <= 1'b0;
      kind        <= '0;
      from_node   <= '0;
      to_node     <= '0;
      edge_weight_out <= '0;
      first_visit <= 1'b0;
    end else begin
      state       <= state_next;
      done_strobe <= 1'b0;
      kind        <= K_REJECT;
      from_node   <= '0;
      to_node     <= '0;
      edge_weight_out <= '0;
      first_visit <= 1'b0;
      if (cfg_we) begin
        walk_order <= cfg_data;
      end
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        S_IDLE: begin
          if (accept) begin
            req_a   <= node_a;
            req_b   <= node_b;
            req_rel <= relation;
            req_w   <= edge_weight_in;
            case (op)
              OP_ADD_NODE: begin
                if (32'(node_count) >= MAX_NODES) begin
                  done_strobe <= 1'b1;
                end else begin
                  node_count <= node_count + 1'b1;
                end
              end
              OP_ADD_EDGE: begin
                if (!(a_ok && b_ok && rel_ok)) done_strobe <= 1'b1;
              end
              OP_START: begin
                done_strobe <= 1'b1;
                if (a_ok && rel_ok) begin
                  visited     <= MAX_NODES'(1) << node_a;
                  frontier[0] <= node_a;
                  head        <= '0;
                  tail        <= CW'(1);
                  row_open    <= 1'b0;
                  scan_pos    <= '0;
                  cur         <= node_a;
                  wrel        <= relation;
                  walk_active <= 1'b1;
                  kind        <= K_VISIT;
                  from_node   <= node_a;
                  first_visit <= 1'b1;
                end
              end
              default: begin
                if (!walk_active) done_strobe <= 1'b1;
              end
            endcase
          end
        end
        S_POP: begin
          if (fr_empty) begin
            walk_active <= 1'b0;
            row_open    <= 1'b0;
            done_strobe <= 1'b1;
            kind        <= K_DONE;
          end else begin
            if (!walk_order) begin
              cur  <= frontier[NIW'(head)];
              head <= head + 1'b1;
            end else begin
              cur  <= frontier[NIW'(tail - 1'b1)];
              tail <= tail - 1'b1;
            end
            scan_pos <= '0;
            row_open <= 1'b1;
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            hit_e    <= first_e;
            hit_fv   <= !visited[first_e];
            scan_pos <= CW'(first_e) + 1'b1;
            if (!visited[first_e]) begin
              visited[first_e] <= 1'b1;
              if (32'(tail) < MAX_NODES) begin
                frontier[NIW'(tail)] <= first_e;
                tail <= tail + 1'b1;
              end
            end
          end else begin
            row_open <= 1'b0;
          end
        end
        S_OUT: begin
          done_strobe     <= 1'b1;
          kind            <= K_EDGE;
          from_node       <= cur;
          to_node         <= hit_e;
          edge_weight_out <= wt_rdata;
          first_visit     <= hit_fv;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail) else $error("frontier head passed tail");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> !done_strobe) else $error("result during scan");
  a_edge_cur_visited: assert property (@(posedge clk) disable iff (rst)
    (done_strobe && kind == K_EDGE) |-> visited[from_node])
    else $error("explored edge from unvisited node");
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    32'(tail) <= MAX_NODES) else $error("frontier overflow");
`endif

endmodule
